FILE: src/hrsp_pkg.sv
`timescale 1ns / 1ps

package hrsp_pkg;

	localparam int unsigned METHOD_MAX_CHARS_DEF = 7;
	localparam int unsigned MID_DEPTH_DEF        = 2;
	localparam int unsigned OUT_DEPTH_DEF        = 2;

	localparam int unsigned MCNT_W = 3;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PATH_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TAIL_LENGTH = 1'd1;

	localparam logic [7:0] MAX_PATH_RST = 8'd255;
	localparam logic [7:0] MAX_TAIL_RST = 8'd63;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [63:0] STR_GET    = 64'h474554;
	localparam logic [63:0] STR_POST   = 64'h504F5354;
	localparam logic [63:0] STR_PUT    = 64'h505554;
	localparam logic [63:0] STR_DELETE = 64'h44454C455445;

	localparam logic [MCNT_W-1:0] LEN_GET    = 3'd3;
	localparam logic [MCNT_W-1:0] LEN_POST   = 3'd4;
	localparam logic [MCNT_W-1:0] LEN_PUT    = 3'd3;
	localparam logic [MCNT_W-1:0] LEN_DELETE = 3'd6;

	localparam logic [2:0] PH_METHOD = 3'd0;
	localparam logic [2:0] PH_PATH   = 3'd1;
	localparam logic [2:0] PH_TAIL   = 3'd2;
	localparam logic [2:0] PH_HSTART = 3'd3;
	localparam logic [2:0] PH_KEY    = 3'd4;
	localparam logic [2:0] PH_VALUE  = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	localparam logic [2:0] ST_PARSING    = 3'd0;
	localparam logic [2:0] ST_COMPLETE   = 3'd1;
	localparam logic [2:0] ST_BAD_METHOD = 3'd2;
	localparam logic [2:0] ST_BAD_PATH   = 3'd3;
	localparam logic [2:0] ST_BAD_BUFFER = 3'd4;

	localparam logic [2:0] METH_NONE   = 3'd0;
	localparam logic [2:0] METH_GET    = 3'd1;
	localparam logic [2:0] METH_POST   = 3'd2;
	localparam logic [2:0] METH_PUT    = 3'd3;
	localparam logic [2:0] METH_DELETE = 3'd4;

	localparam logic [1:0] CLS_NONE  = 2'd0;
	localparam logic [1:0] CLS_PATH  = 2'd1;
	localparam logic [1:0] CLS_KEY   = 2'd2;
	localparam logic [1:0] CLS_VALUE = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       is_space;
		logic       is_colon;
		logic       is_lf;
	} mid_entry_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] byte_class;
		logic       field_end;
		logic [2:0] method_code;
		logic [2:0] parse_status;
		logic       request_end;
	} result_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           wdata;
	} cfg_wr_t;

endpackage

FILE: src/hrsp_queue.sv
`timescale 1ns / 1ps

module hrsp_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             wr_en;
	logic             rd_en;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue count above depth");

	a_ptr_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (rd_ptr_q == wr_ptr_q))
		else $error("queue pointers disagree with count");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !wr_en) |=> !full)
		else $error("queue still full after pop");

endmodule

FILE: src/hrsp_front.sv
`timescale 1ns / 1ps

module hrsp_front #(
	parameter int unsigned MID_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 mid_pop,
	output hrsp_pkg::mid_entry_t mid_head,
	output logic                 mid_empty
);

	import hrsp_pkg::*;

	mid_entry_t ent;

	always_comb begin
		ent.data_byte = data_byte;
		ent.last_byte = last_byte;
		ent.is_space  = (data_byte == CH_SPACE);
		ent.is_colon  = (data_byte == CH_COLON);
		ent.is_lf     = (data_byte == CH_LF);
	end

	hrsp_queue #(
		.WIDTH($bits(mid_entry_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (ent),
		.full  (full),
		.pop   (mid_pop),
		.rdata (mid_head),
		.empty (mid_empty)
	);

endmodule

FILE: src/hrsp_back.sv
`timescale 1ns / 1ps

module hrsp_back #(
	parameter int unsigned METHOD_MAX_CHARS = hrsp_pkg::METHOD_MAX_CHARS_DEF,
	parameter int unsigned OUT_DEPTH        = hrsp_pkg::OUT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hrsp_pkg::cfg_wr_t    cfg,
	input  hrsp_pkg::mid_entry_t mid_head,
	input  logic                 mid_empty,
	output logic                 mid_pop,
	input  logic                 pop,
	output hrsp_pkg::result_t    res_head,
	output logic                 empty
);

	import hrsp_pkg::*;

	localparam int unsigned CharW = 8 * METHOD_MAX_CHARS;

	logic [7:0]        max_path_q;
	logic [7:0]        max_tail_q;
	logic [2:0]        phase_q;
	logic [CharW-1:0]  chars_q;
	logic [MCNT_W-1:0] count_q;
	logic [7:0]        fc_q;
	logic              skip_q;
	logic [2:0]        meth_q;
	logic [2:0]        stat_q;

	logic [2:0]        phase_d;
	logic [CharW-1:0]  chars_d;
	logic [MCNT_W-1:0] count_d;
	logic [7:0]        fc_d;
	logic              skip_d;
	logic [2:0]        meth_d;
	logic [2:0]        stat_d;

	logic [CharW-1:0]  chars_sh;
	logic [MCNT_W-1:0] count_inc;
	logic [CharW-1:0]  m_chars;
	logic [MCNT_W-1:0] m_cnt;
	logic [2:0]        m_code;
	logic              m_full;
	logic [1:0]        cls;
	logic              fend;
	logic              out_full;
	logic              take;
	result_t           res;

	assign take    = !mid_empty && !out_full;
	assign mid_pop = take;

	assign chars_sh  = {chars_q[CharW-9:0], mid_head.data_byte};
	assign count_inc = count_q + 1'b1;
	assign m_full    = ({1'b0, count_inc} >= (MCNT_W + 1)'(METHOD_MAX_CHARS))
		|| (count_inc == '0);
	assign m_chars   = mid_head.is_space ? chars_q : chars_sh;
	assign m_cnt     = mid_head.is_space ? count_q : count_inc;

	always_comb begin
		priority if (m_cnt == LEN_GET && 64'(m_chars) == STR_GET) begin
			m_code = METH_GET;
		end else if (m_cnt == LEN_POST && 64'(m_chars) == STR_POST) begin
			m_code = METH_POST;
		end else if (m_cnt == LEN_PUT && 64'(m_chars) == STR_PUT) begin
			m_code = METH_PUT;
		end else if (m_cnt == LEN_DELETE && 64'(m_chars) == STR_DELETE) begin
			m_code = METH_DELETE;
		end else begin
			m_code = METH_NONE;
		end
	end

	always_comb begin
		phase_d = phase_q;
		chars_d = chars_q;
		count_d = count_q;
		fc_d    = fc_q;
		skip_d  = skip_q;
		meth_d  = meth_q;
		stat_d  = stat_q;
		cls     = CLS_NONE;
		fend    = 1'b0;

		unique case (phase_q)
			PH_METHOD: begin
				if (!mid_head.is_space) begin
					chars_d = chars_sh;
					count_d = count_inc;
				end
				if (mid_head.is_space || m_full) begin
					if (m_code == METH_NONE) begin
						stat_d  = ST_BAD_METHOD;
						phase_d = PH_DONE;
					end else begin
						meth_d  = m_code;
						phase_d = PH_PATH;
						fc_d    = '0;
						skip_d  = !mid_head.is_space;
					end
				end
			end
			PH_PATH: begin
				priority if (skip_q) begin
					skip_d = 1'b0;
				end else if (mid_head.is_space) begin
					fend = 1'b1;
					if (max_tail_q == '0) begin
						stat_d  = ST_BAD_BUFFER;
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_TAIL;
						fc_d    = 8'd1;
					end
				end else if (fc_q == max_path_q) begin
					stat_d  = ST_BAD_PATH;
					phase_d = PH_DONE;
				end else begin
					cls  = CLS_PATH;
					fc_d = fc_q + 1'b1;
				end
			end
			PH_TAIL: begin
				priority if (mid_head.is_lf) begin
					phase_d = PH_HSTART;
					fc_d    = '0;
				end else if (fc_q == max_tail_q) begin
					stat_d  = ST_BAD_BUFFER;
					phase_d = PH_DONE;
				end else begin
					fc_d = fc_q + 1'b1;
				end
			end
			PH_HSTART, PH_KEY: begin
				priority if (phase_q == PH_HSTART && mid_head.is_lf) begin
					stat_d  = ST_COMPLETE;
					phase_d = PH_DONE;
				end else if (mid_head.is_colon) begin
					fend    = 1'b1;
					phase_d = PH_VALUE;
					skip_d  = 1'b1;
				end else begin
					cls     = CLS_KEY;
					phase_d = PH_KEY;
				end
			end
			PH_VALUE: begin
				priority if (skip_q) begin
					skip_d = 1'b0;
				end else if (mid_head.is_lf) begin
					fend    = 1'b1;
					phase_d = PH_HSTART;
				end else begin
					cls = CLS_VALUE;
				end
			end
			default: begin
			end
		endcase

		// buffer end settles a status still open
		if (mid_head.last_byte && stat_d == ST_PARSING) begin
			stat_d = (phase_d >= PH_HSTART) ? ST_COMPLETE : ST_BAD_BUFFER;
		end

		res.out_byte     = mid_head.data_byte;
		res.byte_class   = cls;
		res.field_end    = fend;
		res.method_code  = meth_d;
		res.parse_status = stat_d;
		res.request_end  = mid_head.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_path_q <= MAX_PATH_RST;
			max_tail_q <= MAX_TAIL_RST;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_MAX_PATH_LENGTH: max_path_q <= cfg.wdata;
				REG_MAX_TAIL_LENGTH: max_tail_q <= cfg.wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			chars_q <= '0;
			count_q <= '0;
			fc_q    <= '0;
			skip_q  <= 1'b0;
			meth_q  <= METH_NONE;
			stat_q  <= ST_PARSING;
		end else if (take) begin
			if (mid_head.last_byte) begin
				phase_q <= PH_METHOD;
				chars_q <= '0;
				count_q <= '0;
				fc_q    <= '0;
				skip_q  <= 1'b0;
				meth_q  <= METH_NONE;
				stat_q  <= ST_PARSING;
			end else begin
				phase_q <= phase_d;
				chars_q <= chars_d;
				count_q <= count_d;
				fc_q    <= fc_d;
				skip_q  <= skip_d;
				meth_q  <= meth_d;
				stat_q  <= stat_d;
			end
		end
	end

	hrsp_queue #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (res_head),
		.empty (empty)
	);

	a_done_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> (stat_q != ST_PARSING))
		else $error("done phase with open status");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mid_head.last_byte) |=> (phase_q == PH_METHOD && stat_q == ST_PARSING
			&& meth_q == METH_NONE))
		else $error("no restart after buffer end");

	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mid_head.last_byte) |-> (res.parse_status != ST_PARSING))
		else $error("buffer end without final status");

	a_path_has_method: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PATH || phase_q == PH_TAIL) |-> (meth_q != METH_NONE))
		else $error("path phase without method");

endmodule

FILE: src/http_request_stream_parser_unit.sv
// A pushed byte passes the front queue and the tagger and is popped from the output queue.
// Throughput: one byte per cycle, each updating the parse state, while the front queue
// holds a byte and the output queue has room. Each side stalls on its own through a
// two-entry queue. Reset (arst_n low, asynchronous) empties both queues, sets the limits
// to 255 and 63 and puts the parser in the method phase with no method and status parsing.
`timescale 1ns / 1ps

module http_request_stream_parser_unit #(
	parameter int unsigned METHOD_MAX_CHARS = hrsp_pkg::METHOD_MAX_CHARS_DEF,
	parameter int unsigned MID_DEPTH        = hrsp_pkg::MID_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH        = hrsp_pkg::OUT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     out_byte,
	output logic [1:0]                     byte_class,
	output logic                           field_end,
	output logic [2:0]                     method_code,
	output logic [2:0]                     parse_status,
	output logic                           request_end,
	input  logic                           cfg_we,
	input  logic [hrsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_wdata
);

	import hrsp_pkg::*;

	mid_entry_t mid_head;
	logic       mid_empty;
	logic       mid_pop;
	cfg_wr_t    cfg;
	result_t    res_head;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	hrsp_front #(
		.MID_DEPTH(MID_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.mid_pop  (mid_pop),
		.mid_head (mid_head),
		.mid_empty(mid_empty)
	);

	hrsp_back #(
		.METHOD_MAX_CHARS(METHOD_MAX_CHARS),
		.OUT_DEPTH       (OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.mid_head (mid_head),
		.mid_empty(mid_empty),
		.mid_pop  (mid_pop),
		.pop      (pop),
		.res_head (res_head),
		.empty    (empty)
	);

	assign out_byte     = res_head.out_byte;
	assign byte_class   = res_head.byte_class;
	assign field_end    = res_head.field_end;
	assign method_code  = res_head.method_code;
	assign parse_status = res_head.parse_status;
	assign request_end  = res_head.request_end;

endmodule

FILE: tb/sv/http_request_stream_parser_unit_tb.sv
`timescale 1ns / 1ps

module http_request_stream_parser_unit_tb;
	import hrsp_pkg::*;

	localparam int unsigned IDLE_LIMIT = 1000;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 push         = 1'b0;
	logic                 full;
	logic [7:0]           data_byte    = 8'h00;
	logic                 last_byte    = 1'b0;
	logic                 empty;
	logic                 pop          = 1'b0;
	logic [7:0]           out_byte;
	logic [1:0]           byte_class;
	logic                 field_end;
	logic [2:0]           method_code;
	logic [2:0]           parse_status;
	logic                 request_end;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_MAX_PATH_LENGTH;
	logic [7:0]           cfg_wdata    = 8'h00;

	http_request_stream_parser_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.byte_class  (byte_class),
		.field_end   (field_end),
		.method_code (method_code),
		.parse_status(parse_status),
		.request_end (request_end),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// parser mirror
	logic [7:0]  path_lim = MAX_PATH_RST;
	logic [7:0]  tail_lim = MAX_TAIL_RST;
	logic [2:0]  ph       = PH_METHOD;
	logic [55:0] mth_buf  = '0;
	logic [2:0]  mth_len  = '0;
	logic [7:0]  fld_len  = '0;
	logic        skip     = 1'b0;
	logic [2:0]  meth     = METH_NONE;
	logic [2:0]  status   = ST_PARSING;

	result_t     tagged_q[$];
	logic [7:0]  req_buf[$];
	string       verbs[4] = '{"GET", "POST", "PUT", "DELETE"};

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int errors       = 0;
	int n_sent       = 0;
	int n_requests   = 0;
	int n_checked    = 0;
	int n_complete   = 0;
	int n_failed     = 0;
	int idle_cycles  = 0;

	function automatic void abort_parse(input logic [2:0] code);
		status = code;
		ph     = PH_DONE;
	endfunction

	function automatic void pick_method(input logic skip_next);
		logic [2:0] m;
		m = METH_NONE;
		if (mth_len == LEN_GET && mth_buf == STR_GET) m = METH_GET;
		else if (mth_len == LEN_POST && mth_buf == STR_POST) m = METH_POST;
		else if (mth_len == LEN_PUT && mth_buf == STR_PUT) m = METH_PUT;
		else if (mth_len == LEN_DELETE && mth_buf == STR_DELETE) m = METH_DELETE;
		if (m == METH_NONE) begin
			abort_parse(ST_BAD_METHOD);
		end else begin
			meth    = m;
			ph      = PH_PATH;
			fld_len = '0;
			skip    = skip_next;
		end
	endfunction

	function automatic void tail_step(input logic [7:0] b);
		if (b == CH_LF) begin
			ph      = PH_HSTART;
			fld_len = '0;
		end else if (fld_len == tail_lim) begin
			abort_parse(ST_BAD_BUFFER);
		end else begin
			fld_len = fld_len + 8'd1;
		end
	endfunction

	function automatic result_t tag_byte(input logic [7:0] b, input logic l);
		result_t    r;
		logic [1:0] cls;
		logic       fe;
		cls = CLS_NONE;
		fe  = 1'b0;
		case (ph)
			PH_METHOD: begin
				if (b == CH_SPACE) begin
					pick_method(1'b0);
				end else begin
					mth_buf = {mth_buf[47:0], b};
					mth_len = mth_len + 3'd1;
					if (mth_len >= METHOD_MAX_CHARS_DEF || mth_len == 3'd0) pick_method(1'b1);
				end
			end
			PH_PATH: begin
				if (skip) begin
					skip = 1'b0;
				end else if (b == CH_SPACE) begin
					fe      = 1'b1;
					ph      = PH_TAIL;
					fld_len = '0;
					tail_step(b);
				end else if (fld_len == path_lim) begin
					abort_parse(ST_BAD_PATH);
				end else begin
					cls     = CLS_PATH;
					fld_len = fld_len + 8'd1;
				end
			end
			PH_TAIL: begin
				tail_step(b);
			end
			PH_HSTART, PH_KEY: begin
				if (ph == PH_HSTART && b == CH_LF) begin
					status = ST_COMPLETE;
					ph     = PH_DONE;
				end else if (b == CH_COLON) begin
					fe   = 1'b1;
					ph   = PH_VALUE;
					skip = 1'b1;
				end else begin
					cls = CLS_KEY;
					ph  = PH_KEY;
				end
			end
			PH_VALUE: begin
				if (skip) begin
					skip = 1'b0;
				end else if (b == CH_LF) begin
					fe = 1'b1;
					ph = PH_HSTART;
				end else begin
					cls = CLS_VALUE;
				end
			end
			default: ;
		endcase
		if (l && status == ST_PARSING) status = (ph >= PH_HSTART) ? ST_COMPLETE : ST_BAD_BUFFER;
		r.out_byte     = b;
		r.byte_class   = cls;
		r.field_end    = fe;
		r.method_code  = meth;
		r.parse_status = status;
		r.request_end  = l;
		if (l) begin
			ph      = PH_METHOD;
			mth_buf = '0;
			mth_len = '0;
			fld_len = '0;
			skip    = 1'b0;
			meth    = METH_NONE;
			status  = ST_PARSING;
		end
		return r;
	endfunction

	// one byte transaction; push stays high afterwards unless the next call idles or drain lowers it
	task automatic send_byte(input logic [7:0] d, input logic l);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct && gap < 30) gap++;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (full);
		tagged_q.insert(tagged_q.size(), tag_byte(d, l));
		n_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
		n_requests++;
	endtask

	task automatic send_request();
		foreach (req_buf[i]) send_byte(req_buf[i], i == req_buf.size() - 1);
		n_requests++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (tagged_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_limits(input logic [7:0] p, input logic [7:0] t);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_PATH_LENGTH;
		cfg_wdata <= p;
		@(posedge clk);
		path_lim = p;
		cfg_index <= REG_MAX_TAIL_LENGTH;
		cfg_wdata <= t;
		@(posedge clk);
		tail_lim = t;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] rand_char(input logic [7:0] avoid);
		logic [7:0] c;
		do begin
			if ($urandom_range(9) == 0) c = 8'($urandom_range(255));
			else c = 8'($urandom_range(33, 126));
		end while (c == avoid);
		return c;
	endfunction

	function automatic int pick_len(input int lim);
		int r;
		r = $urandom_range(9);
		if (r < 8) return $urandom_range(0, 12);
		if (r == 8) return lim;
		return lim + 1;
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		req_buf.insert(req_buf.size(), b);
	endfunction

	function automatic void build_request();
		int    n;
		int    nh;
		string v;
		req_buf.delete();
		if ($urandom_range(99) < 12) begin
			n = $urandom_range(1, 16);
			repeat (n) add_byte(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(0, 8);
			repeat (n) add_byte(8'($urandom_range(65, 90)));
			if (n < METHOD_MAX_CHARS_DEF) add_byte(CH_SPACE);
		end else begin
			v = verbs[$urandom_range(3)];
			for (int i = 0; i < v.len(); i++) add_byte(v[i]);
			add_byte(CH_SPACE);
		end
		n = pick_len(path_lim);
		repeat (n) add_byte(rand_char(CH_SPACE));
		add_byte(CH_SPACE);
		n = pick_len(int'(tail_lim) - 1);
		repeat (n) add_byte(rand_char(CH_LF));
		add_byte(CH_LF);
		nh = $urandom_range(0, 4);
		repeat (nh) begin
			n = $urandom_range(1, 8);
			repeat (n) add_byte(rand_char(CH_COLON));
			add_byte(CH_COLON);
			add_byte($urandom_range(3) == 0 ? 8'($urandom_range(255)) : CH_SPACE);
			n = $urandom_range(0, 10);
			repeat (n) add_byte(rand_char(CH_LF));
			add_byte(CH_LF);
		end
		if ($urandom_range(9) != 0) add_byte(CH_LF);
		if ($urandom_range(4) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) add_byte(8'($urandom_range(255)));
		end
		if ($urandom_range(6) == 0) begin
			n = $urandom_range(1, req_buf.size());
			while (req_buf.size() > n) void'(req_buf.pop_back());
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	result_t want;

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (tagged_q.size() == 0) begin
					$error("unexpected transaction: out_byte %0d with nothing pending", out_byte);
					errors++;
				end else begin
					want = tagged_q.pop_front();
					check_field("out_byte", want.out_byte, out_byte);
					check_field("byte_class", want.byte_class, byte_class);
					check_field("field_end", want.field_end, field_end);
					check_field("method_code", want.method_code, method_code);
					check_field("parse_status", want.parse_status, parse_status);
					check_field("request_end", want.request_end, request_end);
					n_checked++;
					if (want.request_end) begin
						if (want.parse_status == ST_COMPLETE) n_complete++;
						else n_failed++;
					end
				end
			end
			pop <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("http_request_stream_parser_unit regression: fail");
				$finish;
			end
		end
	end

	// reset limits, all methods, LF in a key, skipped byte after colon
	task automatic test_methods();
		send_text("GET /a HTTP\nk\nq: v\n\n");
		send_text("POST /\n");
		send_text("PUT / \nab");
		send_text("DELETE  x");
	endtask

	task automatic test_bad_methods();
		send_text(" x");
		send_text("PUTPUTPx");
		send_text("get y");
	endtask

	task automatic test_byte_extremes();
		send_text("GET /");
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_text(" \nk:");
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_LF, 1'b1);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_limits();
		set_limits(8'd1, 8'd1);
		send_text("GET /ab");
		send_text("PUT / HTTP\n");
		set_limits(8'd0, 8'd0);
		send_text("GET a b");
		send_text("GET  x");
	endtask

	task automatic test_random_requests(input int n_bytes);
		int start;
		int k;
		start = n_sent;
		k     = 0;
		while (n_sent - start < n_bytes) begin
			if (k % 8 == 0) begin
				case ($urandom_range(3))
					0: set_limits(8'd255, 8'd255);
					1: set_limits(8'd1, 8'd1);
					2: set_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
					default: set_limits(8'($urandom_range(2, 12)), 8'($urandom_range(2, 12)));
				endcase
			end
			build_request();
			send_request();
			k++;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct = 6;
		snk_idle_pct = 54;
		test_methods();
		test_bad_methods();
		test_byte_extremes();
		test_limits();
		test_random_requests(290);
		src_idle_pct = 54;
		snk_idle_pct = 6;
		test_random_requests(290);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_requests(290);
		drain();
		repeat (4) @(posedge clk);
		$display("covered %0d bytes in %0d requests under three idle mixes and varied limits",
			n_sent, n_requests);
		$display("checked %0d transactions: %0d requests complete, %0d ended in error",
			n_checked, n_complete, n_failed);
		if (errors == 0) begin
			$display("http_request_stream_parser_unit regression: pass");
		end else begin
			$display("http_request_stream_parser_unit regression: fail");
		end
		$finish;
	end

endmodule
